FILE: hdl/accel_tilt_angles_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tilt-angle core
// Clocked check helpers used by accel_tilt_angles_core.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_CORE_DEFINES_SVH
`define ACCEL_TILT_ANGLES_CORE_DEFINES_SVH

// condition must never hold while out of reset
`define ATP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ATP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/atp_pkg.sv
// ---------------------------------------------------------------------------
// atp_pkg
// Widths, constants and types of the tilt-angle core.
// ---------------------------------------------------------------------------
package atp_pkg;

    localparam int IN_W        = 16;
    localparam int PITCH_W     = 15;
    localparam int ROLL_W      = 16;
    localparam int COORD_SHIFT = 8;

    // sum of squares and square root
    localparam int SQ_W     = 32;
    localparam int RAD_W    = SQ_W + 2 * COORD_SHIFT;
    localparam int SQRT_W   = RAD_W / 2;
    localparam int REM_W    = SQRT_W + 4;
    localparam int SQRT_LAT = SQRT_W + 2;

    // CORDIC
    localparam int COORD_W           = 28;
    localparam int ANG_W             = 34;
    localparam int TAB_LEN           = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // angle conversion (2^-32 turn to centidegrees)
    localparam int              MAG_W         = 32;
    localparam int              CDEG_W        = 17;
    localparam int              PROD_W        = 48;
    localparam int              MERGE_LAT     = 2;
    localparam logic [15:0]     CDEG_PER_TURN = 16'd36000;
    localparam int              PITCH_LIM     = 9000;
    localparam int              ROLL_LIM      = 18000;

    // output skid
    localparam int SKID_DEPTH = 2;

    typedef logic signed [IN_W-1:0]    t_raw;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ANG_W-1:0]   t_ang;

    localparam t_ang HALF_TURN = t_ang'(64'sd2147483648);

endpackage

FILE: hdl/atp_if.sv
// ---------------------------------------------------------------------------
// atp_in_if / atp_out_if
// Valid/ready channels for accelerometer samples and tilt-angle results.
// ---------------------------------------------------------------------------
interface atp_in_if import atp_pkg::*; ();
    logic valid;
    logic ready;
    t_raw accel_x;
    t_raw accel_y;
    t_raw accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface atp_out_if import atp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [PITCH_W-1:0] pitch_centideg;
    logic signed [ROLL_W-1:0]  roll_centideg;

    modport source (output valid, output pitch_centideg, output roll_centideg,
                    input ready);
    modport sink   (input valid, input pitch_centideg, input roll_centideg,
                    output ready);
endinterface

FILE: hdl/atp_isqrt.sv
// ---------------------------------------------------------------------------
// atp_isqrt
// Pipelined floor(sqrt((x*x + z*z) * 2^16)), one result bit per stage.
// ---------------------------------------------------------------------------
module atp_isqrt import atp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  t_raw              i_x,
    input  t_raw              i_z,
    output logic [SQRT_W-1:0] o_root
);

    logic signed [SQ_W-1:0] w_sqx;
    logic signed [SQ_W-1:0] w_sqz;
    logic [SQ_W-1:0]        r_sqx;
    logic [SQ_W-1:0]        r_sqz;
    logic [RAD_W-1:0]       r_v0;

    logic [REM_W-1:0]  r_rem  [SQRT_W];
    logic [SQRT_W-1:0] r_res  [SQRT_W];
    logic [RAD_W-1:0]  r_v    [SQRT_W];
    logic [REM_W-1:0]  n_rem  [SQRT_W];
    logic [SQRT_W-1:0] n_res  [SQRT_W];
    logic [RAD_W-1:0]  n_v    [SQRT_W];
    logic [REM_W-1:0]  w_rem_prev [SQRT_W];
    logic [SQRT_W-1:0] w_res_prev [SQRT_W];
    logic [RAD_W-1:0]  w_v_prev   [SQRT_W];

    assign w_sqx = i_x * i_x;
    assign w_sqz = i_z * i_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx <= w_sqx;
            r_sqz <= w_sqz;
            r_v0  <= {SQ_W'(r_sqx + r_sqz), (2 * COORD_SHIFT)'(0)};
        end
    end

    always_comb begin
        w_rem_prev[0] = '0;
        w_res_prev[0] = '0;
        w_v_prev[0]   = r_v0;
        for (int k = 1; k < SQRT_W; k++) begin
            w_rem_prev[k] = r_rem[k-1];
            w_res_prev[k] = r_res[k-1];
            w_v_prev[k]   = r_v[k-1];
        end
    end

    // restoring digit recurrence, two radicand bits per step
    always_comb begin
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < SQRT_W; k++) begin
            acc   = {w_rem_prev[k][REM_W-3:0], w_v_prev[k][RAD_W-1 -: 2]};
            trial = REM_W'({w_res_prev[k], 2'b01});
            if (acc >= trial) begin
                n_rem[k] = acc - trial;
                n_res[k] = {w_res_prev[k][SQRT_W-2:0], 1'b1};
            end else begin
                n_rem[k] = acc;
                n_res[k] = {w_res_prev[k][SQRT_W-2:0], 1'b0};
            end
            n_v[k] = w_v_prev[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_v   <= n_v;
        end
    end

    assign o_root = r_res[SQRT_W-1];

endmodule

FILE: hdl/atp_cordic.sv
// ---------------------------------------------------------------------------
// atp_cordic
// One vectoring lane: atan2(b, a) in 2^-32 turn, one micro-rotation a stage.
// ---------------------------------------------------------------------------
module atp_cordic import atp_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_a,
    input  t_coord i_b,
    output t_ang   o_ang
);

    t_coord r_x    [STAGES+1];
    t_coord r_y    [STAGES+1];
    t_ang   r_z    [STAGES+1];
    logic   r_zero [STAGES+1];
    t_coord n_x    [1:STAGES];
    t_coord n_y    [1:STAGES];
    t_ang   n_z    [1:STAGES];

    always_comb begin
        for (int i = 1; i <= STAGES; i++) begin
            if (r_y[i-1] >= 0) begin
                n_x[i] = r_x[i-1] + (r_y[i-1] >>> (i - 1));
                n_y[i] = r_y[i-1] - (r_x[i-1] >>> (i - 1));
                n_z[i] = r_z[i-1] + t_ang'(ATAN_TAB[i-1]);
            end else begin
                n_x[i] = r_x[i-1] - (r_y[i-1] >>> (i - 1));
                n_y[i] = r_y[i-1] + (r_x[i-1] >>> (i - 1));
                n_z[i] = r_z[i-1] - t_ang'(ATAN_TAB[i-1]);
            end
        end
    end

    // left half plane: turn by 180 degrees first, then the micro-rotations
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_a == '0) && (i_b == '0);
            if (i_a < 0) begin
                r_x[0] <= -i_a;
                r_y[0] <= -i_b;
                r_z[0] <= (i_b >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                r_x[0] <= i_a;
                r_y[0] <= i_b;
                r_z[0] <= '0;
            end
            for (int i = 1; i <= STAGES; i++) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= n_y[i];
                r_z[i]    <= n_z[i];
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    assign o_ang = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

FILE: hdl/atp_merge.sv
// ---------------------------------------------------------------------------
// atp_merge
// Joins both lanes: turn fraction to rounded, saturated centidegrees.
// ---------------------------------------------------------------------------
module atp_merge import atp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  t_ang                      i_pitch_ang,
    input  t_ang                      i_roll_ang,
    output logic signed [PITCH_W-1:0] o_pitch,
    output logic signed [ROLL_W-1:0]  o_roll
);

    t_ang                      w_p_abs;
    t_ang                      w_r_abs;
    logic [PROD_W-1:0]         r_p_prod;
    logic [PROD_W-1:0]         r_r_prod;
    logic                      r_p_neg;
    logic                      r_r_neg;
    logic [CDEG_W-1:0]         w_p_cdeg;
    logic [CDEG_W-1:0]         w_r_cdeg;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [ROLL_W-1:0]  r_roll;

    // round half up in magnitude, then clamp
    function automatic logic [CDEG_W-1:0] round_sat(logic [PROD_W-1:0] prod,
                                                    logic [CDEG_W-1:0] lim);
        logic [PROD_W:0]   sum;
        logic [CDEG_W-1:0] c;
        sum = {1'b0, prod} + (PROD_W + 1)'(64'd2147483648);
        c   = sum[PROD_W -: CDEG_W];
        return (c > lim) ? lim : c;
    endfunction

    assign w_p_abs = i_pitch_ang[ANG_W-1] ? -i_pitch_ang : i_pitch_ang;
    assign w_r_abs = i_roll_ang[ANG_W-1]  ? -i_roll_ang  : i_roll_ang;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_neg  <= i_pitch_ang[ANG_W-1];
            r_r_neg  <= i_roll_ang[ANG_W-1];
            r_p_prod <= w_p_abs[MAG_W-1:0] * CDEG_PER_TURN;
            r_r_prod <= w_r_abs[MAG_W-1:0] * CDEG_PER_TURN;
        end
    end

    assign w_p_cdeg = round_sat(r_p_prod, CDEG_W'(PITCH_LIM));
    assign w_r_cdeg = round_sat(r_r_prod, CDEG_W'(ROLL_LIM));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pitch <= r_p_neg ? -PITCH_W'(w_p_cdeg) : PITCH_W'(w_p_cdeg);
            r_roll  <= r_r_neg ? -ROLL_W'(w_r_cdeg)  : ROLL_W'(w_r_cdeg);
        end
    end

    assign o_pitch = r_pitch;
    assign o_roll  = r_roll;

endmodule

FILE: hdl/accel_tilt_angles_core.sv
// ---------------------------------------------------------------------------
// accel_tilt_angles_core
// Pitch and roll from one raw three-axis accelerometer sample per beat.
//
//   channel    dir  handshake     payload
//   i_sample   in   valid/ready   accel_x, accel_y, accel_z (s16 counts)
//   o_angles   out  valid/ready   pitch_centideg (s15), roll_centideg (s16)
//
// One sample beat per cycle while the skid has room. In order: squares and
// sum, 24 square-root steps, quadrant pre-rotation, micro-rotations, and
// the centidegree convert.
// Reset clears the valid pipeline and the skid only; no clearing pass.
// A two-beat skid follows the pipeline; i_sample.ready drops only while it is
// full, and the whole pipeline freezes then. No path from ready to ready.
// ---------------------------------------------------------------------------
`include "accel_tilt_angles_core_defines.svh"

module accel_tilt_angles_core import atp_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    atp_in_if.sink    i_sample,
    atp_out_if.source o_angles
);

    localparam int LAT = SQRT_LAT + 1 + CORDIC_STAGES + MERGE_LAT;
    localparam int DLY = SQRT_LAT;

    logic                      w_en;
    logic                      w_push;
    logic                      w_pop;
    logic [LAT-1:0]            r_vld;

    // raw samples held until the root comes out
    t_raw                      r_dx [DLY];
    t_raw                      r_dy [DLY];
    t_raw                      r_dz [DLY];

    logic [SQRT_W-1:0]         w_root;
    t_coord                    w_p_a;
    t_coord                    w_p_b;
    t_coord                    w_r_a;
    t_coord                    w_r_b;
    t_ang                      w_pitch_ang;
    t_ang                      w_roll_ang;
    logic signed [PITCH_W-1:0] w_pitch;
    logic signed [ROLL_W-1:0]  w_roll;

    // output skid
    logic signed [PITCH_W-1:0] r_q_pitch [SKID_DEPTH];
    logic signed [ROLL_W-1:0]  r_q_roll  [SKID_DEPTH];
    logic                      r_wptr;
    logic                      r_rptr;
    logic [1:0]                r_cnt;
    logic [1:0]                n_cnt;

    // pipeline advances whenever the skid can take one more beat
    assign w_en           = (r_cnt != 2'(SKID_DEPTH));
    assign i_sample.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_sample.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx[0] <= i_sample.accel_x;
            r_dy[0] <= i_sample.accel_y;
            r_dz[0] <= i_sample.accel_z;
            for (int k = 1; k < DLY; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
                r_dz[k] <= r_dz[k-1];
            end
        end
    end

    // horizontal magnitude for pitch, scaled by 2^8
    atp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (i_sample.accel_x),
        .i_z    (i_sample.accel_z),
        .o_root (w_root)
    );

    // pitch = atan2(y, r), roll = atan2(-x, z), all on the 2^8 grid
    assign w_p_a = t_coord'(w_root);
    assign w_p_b = t_coord'(r_dy[DLY-1]) <<< COORD_SHIFT;
    assign w_r_a = t_coord'(r_dz[DLY-1]) <<< COORD_SHIFT;
    assign w_r_b = (-t_coord'(r_dx[DLY-1])) <<< COORD_SHIFT;

    atp_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_p_a),
        .i_b   (w_p_b),
        .o_ang (w_pitch_ang)
    );

    atp_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_r_a),
        .i_b   (w_r_b),
        .o_ang (w_roll_ang)
    );

    atp_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_pitch_ang (w_pitch_ang),
        .i_roll_ang  (w_roll_ang),
        .o_pitch     (w_pitch),
        .o_roll      (w_roll)
    );

    assign w_push = w_en && r_vld[LAT-1];
    assign w_pop  = o_angles.valid && o_angles.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_pitch[r_wptr] <= w_pitch;
            r_q_roll[r_wptr]  <= w_roll;
        end
    end

    assign o_angles.valid          = (r_cnt != 2'd0);
    assign o_angles.pitch_centideg = r_q_pitch[r_rptr];
    assign o_angles.roll_centideg  = r_q_roll[r_rptr];

    // checks
    `ATP_ASSERT_NEVER(a_skid_cnt, r_cnt > 2'(SKID_DEPTH), "skid count overflow")
    `ATP_ASSERT_NEXT(a_skid_pop, w_pop && !w_push, r_cnt == $past(r_cnt) - 2'd1, "skid pop lost")
    `ATP_ASSERT_NEVER(a_pitch_rng, o_angles.valid && (o_angles.pitch_centideg > PITCH_LIM || o_angles.pitch_centideg < -PITCH_LIM), "pitch out of range")
    `ATP_ASSERT_NEVER(a_roll_rng, o_angles.valid && (o_angles.roll_centideg > ROLL_LIM || o_angles.roll_centideg < -ROLL_LIM), "roll out of range")

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb - tilt-angle core testbench
// Drives raw accelerometer samples into accel_tilt_angles_core with random
// source gaps and sink stalls, predicts pitch and roll per accepted beat with
// a bit-exact fixed-point CORDIC model, and checks every output beat in order.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atp_pkg::*;

    localparam int STAGES         = CORDIC_STAGES_DEF;
    localparam int LATENCY        = STAGES + 29;
    localparam int RANDOM_BEATS   = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    // atan(2^-i) in units of 2^-32 turn
    localparam longint MICRO_ANGLE [TAB_LEN] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10680094,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861,
        10430,     5215,      2608,      1304,
        652,       326,       163,       81
    };
    localparam longint HALF_TURN_U = 64'sd2147483648;

    typedef struct packed {
        t_raw x;
        t_raw y;
        t_raw z;
    } sample_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  roll;
    } tilt_t;

    logic i_clk;
    logic i_rst_n;

    atp_in_if  sample_if ();
    atp_out_if angles_if ();

    accel_tilt_angles_core #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_angles (angles_if)
    );

    sample_t pending_samples [$];
    tilt_t   tilt_expected   [$];
    int      error_count = 0;
    int      idle_cycles = 0;
    logic    sample_taken = 1'b0;

    // ------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------

    // exact floor square root, digit by digit
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned probe = 64'h4000_0000_0000_0000;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v   = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // vectoring mode; caller guarantees xc >= 0
    function automatic longint cordic_vector(longint xc, longint yc);
        longint ang = 0;
        longint dx;
        longint dy;
        for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
            dx = yc >>> i;
            dy = xc >>> i;
            if (yc >= 0) begin
                xc  = xc + dx;
                yc  = yc - dy;
                ang = ang + MICRO_ANGLE[i];
            end else begin
                xc  = xc - dx;
                yc  = yc + dy;
                ang = ang - MICRO_ANGLE[i];
            end
        end
        return ang;
    endfunction

    // atan2(b, a) in 2^-32 turn; left half-plane is pre-rotated by 180 deg
    function automatic longint atan2_turns(longint b, longint a);
        if (a == 0 && b == 0)
            return 0;
        if (a < 0)
            return ((b >= 0) ? HALF_TURN_U : -HALF_TURN_U) + cordic_vector(-a, -b);
        return cordic_vector(a, b);
    endfunction

    // magnitude rounded half up, clamped, sign put back
    function automatic longint turns_to_centideg(longint ang, longint limit);
        longint unsigned mag;
        longint          c;
        mag = (ang < 0) ? longint'(-ang) : ang;
        c   = longint'((mag * 64'd36000 + 64'h8000_0000) >> 32);
        if (c > limit)
            c = limit;
        return (ang < 0) ? -c : c;
    endfunction

    function automatic tilt_t compute_tilt(sample_t s);
        longint          x;
        longint          y;
        longint          z;
        longint unsigned sumsq;
        longint          radius;
        longint          p;
        longint          q;
        tilt_t           t;
        x      = s.x;
        y      = s.y;
        z      = s.z;
        sumsq  = x * x + z * z;
        radius = int_sqrt(sumsq << (2 * COORD_SHIFT));
        p = turns_to_centideg(atan2_turns(y <<< COORD_SHIFT, radius), PITCH_LIM);
        q = turns_to_centideg(atan2_turns((-x) <<< COORD_SHIFT, z <<< COORD_SHIFT),
                              ROLL_LIM);
        t.pitch = p[PITCH_W-1:0];
        t.roll  = q[ROLL_W-1:0];
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_raw pick_corner();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic t_raw pick_span(int span);
        return t_raw'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      kind;
        int      axis;
        int      mag;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // full range, every bit toggles
            s.x = t_raw'($urandom());
            s.y = t_raw'($urandom());
            s.z = t_raw'($urandom());
        end else if (kind < 50) begin
            // near-static sensor: one axis carries gravity
            s.x  = pick_span(2000);
            s.y  = pick_span(2000);
            s.z  = pick_span(2000);
            axis = $urandom_range(0, 2);
            mag  = $urandom_range(8000, 32767);
            if ($urandom_range(0, 1)) mag = -mag;
            if (axis == 0) s.x = t_raw'(mag);
            else if (axis == 1) s.y = t_raw'(mag);
            else s.z = t_raw'(mag);
        end else if (kind < 65) begin
            // tiny vectors: coarse angles and rounding edges
            s.x = pick_span(8);
            s.y = pick_span(8);
            s.z = pick_span(8);
        end else if (kind < 75) begin
            // zero axes: atan2 origin and axis-aligned cases
            s.x = t_raw'($urandom());
            s.y = t_raw'($urandom());
            s.z = t_raw'($urandom());
            case ($urandom_range(0, 3))
                0: s.x = '0;
                1: s.z = '0;
                2: begin s.x = '0; s.z = '0; end
                default: begin s.x = '0; s.y = '0; end
            endcase
        end else if (kind < 85) begin
            s.x = pick_corner();
            s.y = pick_corner();
            s.z = pick_corner();
        end else begin
            s.x = pick_span(4096);
            s.y = pick_span(4096);
            s.z = pick_span(4096);
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        sample_t directed [$];

        i_rst_n           = 1'b0;
        sample_if.valid   = 1'b0;
        sample_if.accel_x = '0;
        sample_if.accel_y = '0;
        sample_if.accel_z = '0;
        angles_if.ready   = 1'b0;

        directed = '{
            '{16'sd0,      16'sd0,      16'sd0},       // origin for both angles
            '{16'sd0,      16'sd0,      16'sd1},
            '{16'sd0,      16'sd0,     -16'sd1},       // x zero, z negative: +180
            '{16'sd0,      16'sd1,      16'sd0},       // roll origin, pitch +90
            '{16'sd0,     -16'sd1,      16'sd0},
            '{16'sd1,      16'sd0,      16'sd0},
            '{-16'sd1,     16'sd0,      16'sd0},
            '{16'sd0,      16'sd0,     -16'sd16384},
            '{16'sd0,      16'sd32767,  16'sd0},       // pitch clamp at top
            '{16'sd0,     -16'sd32768,  16'sd0},
            '{-16'sd32768, -16'sd32768, -16'sd32768},
            '{16'sd32767,  16'sd32767,  16'sd32767},
            '{16'sd32767,  16'sd0,      16'sd0},
            '{-16'sd32768, 16'sd0,      16'sd0},
            '{16'sd0,      16'sd0,      16'sd32767},
            '{16'sd0,      16'sd0,     -16'sd32768},
            '{-16'sd32768, 16'sd32767, -16'sd32768},
            '{16'sd16384, -16'sd5,     -16'sd1},       // z negative, -x < 0: -180 base
            '{-16'sd16384, 16'sd7,     -16'sd1},
            '{16'sd1,      16'sd0,     -16'sd32768},   // roll near +-180, clamp
            '{-16'sd1,     16'sd0,     -16'sd32768},
            '{16'sd0,      16'sd100,   -16'sd1}
        };
        foreach (directed[i])
            pending_samples.push_back(directed[i]);
        repeat (RANDOM_BEATS)
            pending_samples.push_back(random_sample());

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all samples in, all results out, then let the pipe run dry
        while (pending_samples.size() != 0 || sample_if.valid)
            @(posedge i_clk);
        while (tilt_expected.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 16) @(posedge i_clk);

        if (error_count == 0 && tilt_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Sample driver: falling edge, one beat per free slot, random gaps
    // ------------------------------------------------------------------
    int gap_left  = 0;
    int src_calm  = 0;

    always @(negedge i_clk) begin
        sample_t s;
        if (i_rst_n) begin
            // slot is free when nothing is offered or the last beat was taken
            if (!sample_if.valid || sample_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    sample_if.valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s = pending_samples.pop_front();
                    sample_if.valid   <= 1'b1;
                    sample_if.accel_x <= s.x;
                    sample_if.accel_y <= s.y;
                    sample_if.accel_z <= s.z;
                    if (src_calm > 0) begin
                        src_calm--;
                        gap_left = 0;
                    end else if ($urandom_range(0, 99) < 3) begin
                        src_calm = $urandom_range(40, 150);
                        gap_left = 0;
                    end else begin
                        gap_left = pick_idle();
                    end
                end else begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: falling edge, random stalls with calm stretches
    // ------------------------------------------------------------------
    int stall_left = 0;
    int sink_calm  = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                angles_if.ready <= 1'b0;
            end else if (sink_calm > 0) begin
                sink_calm--;
                angles_if.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 2) begin
                sink_calm = $urandom_range(40, 150);
                angles_if.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 70) begin
                angles_if.ready <= 1'b1;
            end else begin
                stall_left = pick_idle();
                angles_if.ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge; predict on input beats, check output beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sample_t s;
        tilt_t   want;
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
        end else begin
            sample_taken <= sample_if.valid && sample_if.ready;
            if (sample_if.valid && sample_if.ready) begin
                s.x = sample_if.accel_x;
                s.y = sample_if.accel_y;
                s.z = sample_if.accel_z;
                tilt_expected.push_back(compute_tilt(s));
            end
            if (angles_if.valid && angles_if.ready) begin
                if (tilt_expected.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected, pitch %0d roll %0d",
                                 $time, angles_if.pitch_centideg, angles_if.roll_centideg);
                end else begin
                    want = tilt_expected.pop_front();
                    if (angles_if.pitch_centideg !== want.pitch) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: pitch mismatch, expected %0d actual %0d",
                                     $time, want.pitch, angles_if.pitch_centideg);
                    end
                    if (angles_if.roll_centideg !== want.roll) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: roll mismatch, expected %0d actual %0d",
                                     $time, want.roll, angles_if.roll_centideg);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_if.valid && sample_if.ready) ||
                (angles_if.valid && angles_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, tilt_expected.size());
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

FILE: accel_tilt_angles_core.f
+incdir+hdl
hdl/atp_pkg.sv
hdl/atp_if.sv
hdl/atp_isqrt.sv
hdl/atp_cordic.sv
hdl/atp_merge.sv
hdl/accel_tilt_angles_core.sv
tb/tb.sv
